>>> rtl/mpmc_pkg.sv
// Shared codes for the multi-pattern match counter.
// Transaction types, status codes and count width. No dependencies.
package mpmc_pkg;
   localparam int CountW = 16;
   localparam logic [CountW-1:0] COUNT_MAX = '1;

   localparam logic [2:0] TYPE_PAT_LETTER = 3'd0;
   localparam logic [2:0] TYPE_PAT_END    = 3'd1;
   localparam logic [2:0] TYPE_BUILD      = 3'd2;
   localparam logic [2:0] TYPE_TXT_LETTER = 3'd3;
   localparam logic [2:0] TYPE_TXT_END    = 3'd4;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_FULL         = 3'd1;
   localparam logic [2:0] ST_AFTER_BUILD  = 3'd2;
   localparam logic [2:0] ST_BEFORE_BUILD = 3'd3;
   localparam logic [2:0] ST_SAT          = 3'd4;
endpackage

>>> rtl/multi_pattern_match_counter_unit.sv
// Aho-Corasick match counter: trie load, BFS build and text scan.
// Uses mpmc_pkg. Goto, word count, fail, visited and queue memories.

// Aho-Corasick multi-pattern counter. After reset the unit sweeps the goto
// table, clearing the word count, fail and visited memories, before it takes
// any transaction. One transaction is worked at a time; a finished result
// waits in the output register while the next transaction is taken. A pattern
// letter reads goto, then S_PL; end of pattern reads the word count, then S_EP.
// A text letter passes S_TL, then S_WRD and S_WCHK per fail-chain node it marks,
// stopping at the root, a node already marked or the step cap; others go straight to S_RSP.
// Build steps S_BRR, S_BRW per root letter, S_BQ, S_BU, S_BF per queued node
// and S_BV, S_BG, S_BW per node and letter, set by the single read port of
// each memory. End of text is followed by a sweep of the visited marks.
module multi_pattern_match_counter_unit #(
   parameter int NODES    = 1024,
   parameter int ALPHABET = 26
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [4:0]  req_letter,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [mpmc_pkg::CountW-1:0] rsp_match_count,
   output logic        rsp_text_done
);
   import mpmc_pkg::*;

   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int GW = $clog2(NODES * ALPHABET);
   localparam int GDEPTH = NODES * ALPHABET;
   localparam logic [GW-1:0] ALPHA_G = GW'(ALPHABET);
   localparam logic [GW-1:0] GLAST = GW'(GDEPTH - 1);
   localparam logic [NW-1:0] NLAST = NW'(NODES - 1);
   localparam logic [CW-1:0] CLAST = CW'(ALPHABET - 1);
   localparam logic [NW:0] NODES_X = (NW+1)'(NODES);

   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_PL   = 5'd2;
   localparam logic [4:0] S_EP   = 5'd3;
   localparam logic [4:0] S_TL   = 5'd4;
   localparam logic [4:0] S_WRD  = 5'd5;
   localparam logic [4:0] S_WCHK = 5'd6;
   localparam logic [4:0] S_BRR  = 5'd7;
   localparam logic [4:0] S_BRW  = 5'd8;
   localparam logic [4:0] S_BQ   = 5'd9;
   localparam logic [4:0] S_BU   = 5'd10;
   localparam logic [4:0] S_BF   = 5'd11;
   localparam logic [4:0] S_BV   = 5'd12;
   localparam logic [4:0] S_BG   = 5'd13;
   localparam logic [4:0] S_BW   = 5'd14;
   localparam logic [4:0] S_RSP  = 5'd15;
   localparam logic [4:0] S_VCLR = 5'd16;

   logic [NW-1:0]     goto_mem [GDEPTH];
   logic [CountW-1:0] wc_mem   [NODES];
   logic [NW-1:0]     fail_mem [NODES];
   logic              vis_mem  [NODES];
   logic [NW-1:0]     q_mem    [NODES];

   logic [4:0]        state_ff, state_in;
   logic [GW-1:0]     clr_ff, clr_in;
   logic [NW-1:0]     nu_ff, nu_in, ins_ff, ins_in, tc_ff, tc_in;
   logic [NW-1:0]     u_ff, u_in, fu_ff, fu_in, v_ff, v_in;
   logic [CW-1:0]     c_ff, c_in;
   logic [NW:0]       head_ff, head_in, tail_ff, tail_in, steps_ff, steps_in;
   logic [CountW-1:0] total_ff, total_in;
   logic              built_ff, built_in, done_ff, done_in;
   logic [2:0]        st_ff, st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [CountW-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_done_ff, rsp_done_in;

   logic [NW-1:0]     g_rnode, g_wnode, g_wdata, g_rdata;
   logic [CW-1:0]     g_rchr, g_wchr;
   logic [GW-1:0]     g_raddr, g_waddr;
   logic              g_we, g_wdirect;
   logic [NW-1:0]     n_raddr, wc_waddr, fail_waddr, vis_waddr, q_raddr, q_waddr;
   logic [CountW-1:0] wc_wdata, wc_rdata;
   logic [NW-1:0]     fail_wdata, fail_rdata, q_wdata, q_rdata;
   logic              wc_we, fail_we, vis_we, vis_wdata, vis_rdata, q_we;
   logic              accept, letter_ok;
   logic [CountW:0]   sum;

   assign g_raddr = GW'(g_rnode) * ALPHA_G + GW'(g_rchr);
   assign g_waddr = g_wdirect ? clr_ff : GW'(g_wnode) * ALPHA_G + GW'(g_wchr);

   always_ff @(posedge clock) begin
      if (g_we) goto_mem[g_waddr] <= g_wdata;
      g_rdata <= goto_mem[g_raddr];
   end
   always_ff @(posedge clock) begin
      if (wc_we) wc_mem[wc_waddr] <= wc_wdata;
      wc_rdata <= wc_mem[n_raddr];
   end
   always_ff @(posedge clock) begin
      if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
      fail_rdata <= fail_mem[n_raddr];
   end
   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
      vis_rdata <= vis_mem[n_raddr];
   end
   always_ff @(posedge clock) begin
      if (q_we) q_mem[q_waddr] <= q_wdata;
      q_rdata <= q_mem[q_raddr];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign letter_ok = (32'(req_letter) < ALPHABET);
   assign sum = {1'b0, total_ff} + {1'b0, wc_rdata};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_text_done = rsp_done_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      nu_in = nu_ff; ins_in = ins_ff; tc_in = tc_ff;
      u_in = u_ff; fu_in = fu_ff; v_in = v_ff; c_in = c_ff;
      head_in = head_ff; tail_in = tail_ff; steps_in = steps_ff;
      total_in = total_ff; built_in = built_ff; done_in = done_ff; st_in = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff; rsp_count_in = rsp_count_ff;
      rsp_done_in = rsp_done_ff;
      g_rnode = '0; g_rchr = '0; g_wnode = ins_ff; g_wchr = c_ff;
      g_we = 1'b0; g_wdirect = 1'b0; g_wdata = '0;
      n_raddr = u_ff;
      wc_we = 1'b0; wc_waddr = ins_ff; wc_wdata = '0;
      fail_we = 1'b0; fail_waddr = v_ff; fail_wdata = '0;
      vis_we = 1'b0; vis_waddr = u_ff; vis_wdata = 1'b0;
      q_we = 1'b0; q_waddr = tail_ff[NW-1:0]; q_wdata = '0;
      q_raddr = head_ff[NW-1:0];

      unique case (state_ff)
         S_CLR: begin
            g_we = 1'b1; g_wdirect = 1'b1;
            if (clr_ff < GW'(NODES)) begin
               wc_we = 1'b1; wc_waddr = clr_ff[NW-1:0];
               fail_we = 1'b1; fail_waddr = clr_ff[NW-1:0];
               vis_we = 1'b1; vis_waddr = clr_ff[NW-1:0];
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == GLAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               st_in = ST_OK; done_in = 1'b0;
               c_in = CW'(req_letter);
               state_in = S_RSP;
               case (req_type)
                  TYPE_PAT_LETTER: begin
                     if (built_ff) st_in = ST_AFTER_BUILD;
                     else if (letter_ok) begin
                        g_rnode = ins_ff; g_rchr = CW'(req_letter);
                        state_in = S_PL;
                     end
                  end
                  TYPE_PAT_END: begin
                     if (built_ff) st_in = ST_AFTER_BUILD;
                     else if (ins_ff != '0) begin
                        n_raddr = ins_ff;
                        state_in = S_EP;
                     end
                  end
                  TYPE_BUILD: begin
                     if (built_ff) st_in = ST_AFTER_BUILD;
                     else begin
                        c_in = '0; head_in = '0; tail_in = '0;
                        state_in = S_BRR;
                     end
                  end
                  TYPE_TXT_LETTER: begin
                     if (!built_ff) st_in = ST_BEFORE_BUILD;
                     else if (letter_ok) begin
                        g_rnode = tc_ff; g_rchr = CW'(req_letter);
                        state_in = S_TL;
                     end
                  end
                  TYPE_TXT_END: begin
                     if (!built_ff) st_in = ST_BEFORE_BUILD;
                     else done_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_PL: begin
            if (g_rdata == '0) begin
               if ({1'b0, nu_ff} + 1'b1 >= NODES_X) st_in = ST_FULL;
               else begin
                  nu_in = nu_ff + 1'b1; ins_in = nu_ff + 1'b1;
                  g_we = 1'b1; g_wnode = ins_ff; g_wchr = c_ff; g_wdata = nu_ff + 1'b1;
               end
            end else ins_in = g_rdata;
            state_in = S_RSP;
         end
         S_EP: begin
            if (wc_rdata == COUNT_MAX) st_in = ST_SAT;
            else begin
               wc_we = 1'b1; wc_waddr = ins_ff; wc_wdata = wc_rdata + 1'b1;
            end
            ins_in = '0;
            state_in = S_RSP;
         end
         S_TL: begin
            tc_in = g_rdata; u_in = g_rdata; steps_in = '0;
            state_in = S_WRD;
         end
         S_WRD: begin
            n_raddr = u_ff;
            state_in = (u_ff == '0) ? S_RSP : S_WCHK;
         end
         S_WCHK: begin
            if (vis_rdata) state_in = S_RSP;
            else begin
               if (sum[CountW]) begin
                  total_in = COUNT_MAX; st_in = ST_SAT;
               end else total_in = sum[CountW-1:0];
               vis_we = 1'b1; vis_waddr = u_ff; vis_wdata = 1'b1;
               u_in = fail_rdata;
               steps_in = steps_ff + 1'b1;
               state_in = (steps_ff + 1'b1 >= NODES_X) ? S_RSP : S_WRD;
            end
         end
         // root row: depth-one nodes fail to the root
         S_BRR: begin
            g_rnode = '0; g_rchr = c_ff;
            state_in = S_BRW;
         end
         S_BRW: begin
            if (g_rdata != '0 && tail_ff < NODES_X) begin
               fail_we = 1'b1; fail_waddr = g_rdata; fail_wdata = '0;
               q_we = 1'b1; q_waddr = tail_ff[NW-1:0]; q_wdata = g_rdata;
               tail_in = tail_ff + 1'b1;
            end
            c_in = c_ff + 1'b1;
            if (c_ff == CLAST) state_in = S_BQ;
            else state_in = S_BRR;
         end
         S_BQ: begin
            if (head_ff == tail_ff) begin
               built_in = 1'b1; ins_in = '0;
               state_in = S_RSP;
            end else begin
               q_raddr = head_ff[NW-1:0];
               head_in = head_ff + 1'b1;
               state_in = S_BU;
            end
         end
         S_BU: begin
            u_in = q_rdata; n_raddr = q_rdata;
            state_in = S_BF;
         end
         S_BF: begin
            fu_in = fail_rdata; c_in = '0;
            state_in = S_BV;
         end
         S_BV: begin
            g_rnode = u_ff; g_rchr = c_ff;
            state_in = S_BG;
         end
         S_BG: begin
            v_in = g_rdata;
            g_rnode = fu_ff; g_rchr = c_ff;
            state_in = S_BW;
         end
         S_BW: begin
            if (v_ff != '0) begin
               fail_we = 1'b1; fail_waddr = v_ff; fail_wdata = g_rdata;
               if (tail_ff < NODES_X) begin
                  q_we = 1'b1; q_waddr = tail_ff[NW-1:0]; q_wdata = v_ff;
                  tail_in = tail_ff + 1'b1;
               end
            end else begin
               g_we = 1'b1; g_wnode = u_ff; g_wchr = c_ff; g_wdata = g_rdata;
            end
            c_in = c_ff + 1'b1;
            state_in = (c_ff == CLAST) ? S_BQ : S_BV;
         end
         S_RSP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = st_ff;
               rsp_count_in = total_ff;
               rsp_done_in = done_ff;
               clr_in = '0;
               state_in = done_ff ? S_VCLR : S_IDLE;
            end
         end
         S_VCLR: begin
            vis_we = 1'b1; vis_waddr = clr_ff[NW-1:0]; vis_wdata = 1'b0;
            total_in = '0; tc_in = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff[NW-1:0] == NLAST) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         nu_ff <= '0; ins_ff <= '0; tc_ff <= '0;
         head_ff <= '0; tail_ff <= '0; steps_ff <= '0;
         total_ff <= '0; built_ff <= 1'b0; done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         nu_ff <= nu_in; ins_ff <= ins_in; tc_ff <= tc_in;
         head_ff <= head_in; tail_ff <= tail_in; steps_ff <= steps_in;
         total_ff <= total_in; built_ff <= built_in; done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in; fu_ff <= fu_in; v_ff <= v_in; c_ff <= c_in; st_ff <= st_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff <= rsp_count_in;
      rsp_done_ff <= rsp_done_in;
   end
endmodule

>>> test/tb_multi_pattern_match_counter_unit.sv
// Testbench for multi_pattern_match_counter_unit: trie load, build, text scan.
// Depends on mpmc_pkg and the unit; self-checking against an in-bench predictor.
`timescale 1ns / 1ps

module tb_multi_pattern_match_counter_unit;
   import mpmc_pkg::*;

   localparam int NODES    = 1024;
   localparam int ALPHABET = 26;

   typedef struct {
      logic [2:0] kind;
      logic [4:0] letter;
      bit         drain;
   } req_item_type;

   typedef struct {
      logic [2:0]        status;
      logic [CountW-1:0] count;
      logic              done;
   } match_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_type = 0;
   logic [4:0] req_letter = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_status;
   logic [CountW-1:0] rsp_match_count;
   logic rsp_text_done;

   multi_pattern_match_counter_unit #(.NODES(NODES), .ALPHABET(ALPHABET)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_letter(req_letter),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_match_count(rsp_match_count),
      .rsp_text_done(rsp_text_done)
   );

   // predictor state
   logic [9:0]        trie_next [NODES*ALPHABET];
   logic [CountW-1:0] words_at [NODES];
   logic [9:0]        fail_of [NODES];
   bit                seen [NODES];
   logic [9:0]        bfs_order [NODES];
   int                trie_size, ins_node, scan_node;
   logic [CountW-1:0] scan_total;
   bit                is_built;

   req_item_type     pending_reqs[$];
   match_result_type expected_results[$];
   int               error_count = 0;
   int               sent_count = 0;
   int               got_count = 0;
   int               send_gap = 0;
   int               hold_left = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic build_links();
      int head, tail, u, fu, v;
      head = 0;
      tail = 0;
      for (int c = 0; c < ALPHABET; c++) begin
         v = trie_next[c];
         if (v != 0 && tail < NODES) begin
            fail_of[v] = 0;
            bfs_order[tail++] = 10'(v);
         end
      end
      while (head < tail) begin
         u = bfs_order[head++];
         fu = fail_of[u];
         for (int c = 0; c < ALPHABET; c++) begin
            v = trie_next[u*ALPHABET+c];
            if (v != 0) begin
               fail_of[v] = trie_next[fu*ALPHABET+c];
               if (tail < NODES) bfs_order[tail++] = 10'(v);
            end else begin
               trie_next[u*ALPHABET+c] = trie_next[fu*ALPHABET+c];
            end
         end
      end
   endtask

   task automatic predict_match(input logic [2:0] kind, input logic [4:0] letter);
      match_result_type r;
      int s, u, steps;
      logic [CountW:0] sum;
      r.status = ST_OK;
      r.done = 0;
      case (kind)
         TYPE_PAT_LETTER: begin
            if (is_built) r.status = ST_AFTER_BUILD;
            else if (letter < ALPHABET) begin
               s = ins_node*ALPHABET + letter;
               if (trie_next[s] == 0 && trie_size + 1 >= NODES) r.status = ST_FULL;
               else begin
                  if (trie_next[s] == 0) begin
                     trie_size++;
                     trie_next[s] = 10'(trie_size);
                  end
                  ins_node = trie_next[s];
               end
            end
         end
         TYPE_PAT_END: begin
            if (is_built) r.status = ST_AFTER_BUILD;
            else begin
               if (ins_node != 0) begin
                  if (words_at[ins_node] == COUNT_MAX) r.status = ST_SAT;
                  else words_at[ins_node]++;
               end
               ins_node = 0;
            end
         end
         TYPE_BUILD: begin
            if (is_built) r.status = ST_AFTER_BUILD;
            else begin
               build_links();
               is_built = 1;
               ins_node = 0;
            end
         end
         TYPE_TXT_LETTER: begin
            if (!is_built) r.status = ST_BEFORE_BUILD;
            else if (letter < ALPHABET) begin
               scan_node = trie_next[scan_node*ALPHABET + letter];
               u = scan_node;
               steps = 0;
               while (u != 0 && !seen[u] && steps < NODES) begin
                  sum = scan_total + words_at[u];
                  if (sum > COUNT_MAX) begin
                     sum = COUNT_MAX;
                     r.status = ST_SAT;
                  end
                  scan_total = sum[CountW-1:0];
                  seen[u] = 1;
                  u = fail_of[u];
                  steps++;
               end
            end
         end
         TYPE_TXT_END: begin
            if (!is_built) r.status = ST_BEFORE_BUILD;
            else r.done = 1;
         end
         default: ;
      endcase
      r.count = scan_total;
      if (r.done) begin
         for (int i = 0; i < NODES; i++) seen[i] = 0;
         scan_total = 0;
         scan_node = 0;
      end
      expected_results.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && req_stall) begin
         req_valid <= 1;
      end else begin
         if (req_valid) begin
            predict_match(req_type, req_letter);
            sent_count++;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (pending_reqs.size() != 0 &&
                      (!pending_reqs[0].drain || expected_results.size() == 0)) begin
            req_type <= pending_reqs[0].kind;
            req_letter <= pending_reqs[0].letter;
            pending_reqs.pop_front();
            req_valid <= 1;
            // alternate idle-free bursts with random gaps
            send_gap <= ((sent_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 15);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      int next_hold;
      match_result_type want;
      if (reset) begin
         rsp_stall <= 0;
         hold_left <= 0;
      end else begin
         next_hold = (hold_left > 0) ? hold_left - 1 : 0;
         if (rsp_valid && !rsp_stall) begin
            got_count++;
            if (expected_results.size() == 0) begin
               report("unexpected transaction, status", 32'(rsp_status), 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_match_count !== want.count)
                  report("match_count", 32'(rsp_match_count), 32'(want.count));
               if (rsp_text_done !== want.done)
                  report("text_done", 32'(rsp_text_done), 32'(want.done));
            end
            if (got_count == 1500) next_hold = 400;   // long back-pressure stretch
            else if ((got_count / 80) % 3 == 1) next_hold = 0;
            else next_hold = $urandom_range(0, 15);
         end
         hold_left <= next_hold;
         rsp_stall <= (next_hold != 0);
      end
   end

   task automatic add_req(input logic [2:0] kind, input logic [4:0] letter, input bit drain = 0);
      req_item_type it;
      it.kind = kind;
      it.letter = letter;
      it.drain = drain;
      pending_reqs.push_back(it);
   endtask

   task automatic add_word(input int max_letter, input int len);
      for (int i = 0; i < len; i++)
         add_req(TYPE_PAT_LETTER, 5'($urandom_range(0, max_letter)));
      add_req(TYPE_PAT_END, 5'($urandom_range(0, 31)));
   endtask

   initial begin
      int len;
      for (int i = 0; i < NODES*ALPHABET; i++) trie_next[i] = 0;
      for (int i = 0; i < NODES; i++) begin
         words_at[i] = 0;
         fail_of[i] = 0;
         seen[i] = 0;
      end
      trie_size = 0;
      ins_node = 0;
      scan_node = 0;
      scan_total = 0;
      is_built = 0;

      // directed: text before build, odd types, out-of-range letters, empty pattern
      add_req(TYPE_TXT_LETTER, 5'd2);
      add_req(TYPE_TXT_END, 5'd31);
      add_req(3'd5, 5'd0);
      add_req(3'd6, 5'd17);
      add_req(3'd7, 5'd31);
      add_req(TYPE_PAT_END, 5'd0);
      add_req(TYPE_PAT_LETTER, 5'd31);
      add_req(TYPE_PAT_LETTER, 5'd26);
      add_req(TYPE_PAT_LETTER, 5'd0);
      add_req(TYPE_PAT_END, 5'd0);
      add_req(TYPE_PAT_LETTER, 5'd0);
      add_req(TYPE_PAT_END, 5'd0);
      add_req(TYPE_PAT_LETTER, 5'd0);
      add_req(TYPE_PAT_LETTER, 5'd1);
      add_req(TYPE_PAT_END, 5'd0);
      add_req(TYPE_PAT_LETTER, 5'd25);
      add_req(TYPE_PAT_END, 5'd0);

      // short words over a small alphabet so texts hit often
      for (int i = 0; i < 100; i++) add_word(3, $urandom_range(1, 5));
      // long words over the full alphabet run the node table out
      for (int i = 0; i < 40; i++) begin
         for (int j = 0; j < 20; j++) begin
            if ($urandom_range(0, 19) == 0)
               add_req(TYPE_PAT_LETTER, 5'($urandom_range(26, 31)));
            else add_req(TYPE_PAT_LETTER, 5'($urandom_range(0, 25)));
         end
         add_req(TYPE_PAT_END, 5'($urandom_range(0, 31)));
      end
      // unfinished word at build time
      add_req(TYPE_PAT_LETTER, 5'd2);
      add_req(TYPE_PAT_LETTER, 5'd3);
      add_req(TYPE_BUILD, 5'd9);
      add_req(TYPE_PAT_LETTER, 5'd1);
      add_req(TYPE_PAT_END, 5'd0);
      add_req(TYPE_BUILD, 5'd0);
      add_req(TYPE_TXT_LETTER, 5'd31);
      add_req(TYPE_TXT_END, 5'd0);

      for (int t = 0; t < 40; t++) begin
         len = $urandom_range(1, 24);
         for (int j = 0; j < len; j++) begin
            case ($urandom_range(0, 19))
               0: add_req(TYPE_TXT_LETTER, 5'($urandom_range(0, 31)), t == 20 && j == 0);
               1: add_req(3'($urandom_range(5, 7)), 5'($urandom_range(0, 31)),
                          t == 20 && j == 0);
               2: add_req(TYPE_TXT_LETTER, 5'($urandom_range(0, 25)), t == 20 && j == 0);
               default: add_req(TYPE_TXT_LETTER, 5'($urandom_range(0, 3)), t == 20 && j == 0);
            endcase
         end
         add_req(TYPE_TXT_END, 5'($urandom_range(0, 31)));
      end

      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      wait (pending_reqs.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (2500) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
